/* rtl/lkvt_pkg.sv */
// shared types, operation and status codes for the linear key-value table
package lkvt_pkg;

  // default sizes
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // fixed field widths of the item and the result
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  // operation codes, the spare code acts as a lookup
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] lookup_key;
    logic [FIELD_W-1:0] entry_value;
  } lkvt_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
    logic                table_empty;
  } lkvt_out_t;

endpackage

/* rtl/linear_key_value_table.sv */
// linear key-value table: insertion-ordered store searched one entry at a time
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_stall_o    in_item_i  (kind, lookup_key, entry_value)
//   out      out  out_valid_o / out_stall_i  out_item_o (status, entry_count, table_empty)
//
// one item at a time; a single key comparator walks the stored entries, each one
// read from the registered memory, then compared; insert and lookup scan at most
// the fill count of entries, and remove also moves each later entry down with one
// memory read and one write each
// reset clears the fill count, the sequencer and the output valid; the key and value
// memories are not cleared, only entries below the fill count are ever read
// the result sits in an output register, so a stalled result does not hold the
// next item out; only the following result waits for the output to drain
module linear_key_value_table
  import lkvt_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lkvt_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lkvt_out_t out_item_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // entry index
  localparam int unsigned CW = $clog2(CAPACITY + 1);                  // fill count

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_READ     = 3'd1;
  localparam logic [2:0] S_CMP      = 3'd2;
  localparam logic [2:0] S_RESOLVE  = 3'd3;
  localparam logic [2:0] S_SHIFT_RD = 3'd4;
  localparam logic [2:0] S_SHIFT_WR = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  // storage
  logic [KEY_BITS-1:0]   key_mem   [CAPACITY];
  logic [VALUE_BITS-1:0] value_mem [CAPACITY];
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [VALUE_BITS-1:0] rd_val_q;

  // control and working registers
  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic                  found_q, found_d;
  logic [KIND_W-1:0]     op_q, op_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  out_valid_q, out_valid_d;
  lkvt_out_t             out_q, out_d;

  // memory port controls
  logic                  key_we, val_we;
  logic [IW-1:0]         wr_addr, rd_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_val;

  // field narrowing or widening to the stored widths
  logic [KEY_BITS+FIELD_W-1:0]   key_ext;
  logic [VALUE_BITS+FIELD_W-1:0] val_ext;
  logic [CW+COUNT_W-1:0]         cnt_ext;
  logic [CW-1:0]                 idx_ext;
  logic                          out_free;

  assign key_ext  = {{KEY_BITS{1'b0}}, in_item_i.lookup_key};
  assign val_ext  = {{VALUE_BITS{1'b0}}, in_item_i.entry_value};
  assign cnt_ext  = {{COUNT_W{1'b0}}, count_d};
  assign idx_ext  = CW'(idx_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // shift reads the entry after the current one, the scan reads the current one
  assign rd_addr = (state_q == S_SHIFT_RD) ? (idx_q + IW'(1)) : idx_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    found_d     = found_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    key_we      = 1'b0;
    val_we      = 1'b0;
    wr_addr     = idx_q;
    wr_key      = key_q;
    wr_val      = val_q;

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_item_i.kind;
          key_d   = key_ext[KEY_BITS-1:0];
          val_d   = val_ext[VALUE_BITS-1:0];
          idx_d   = '0;
          found_d = 1'b0;
          // empty table: nothing to scan
          state_d = (count_q == '0) ? S_RESOLVE : S_READ;
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rd_key_q == key_q) begin
          found_d = 1'b1;
          state_d = S_RESOLVE;
        end else if (idx_ext + CW'(1) == count_q) begin
          state_d = S_RESOLVE;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_READ;
        end
      end
      S_RESOLVE: begin
        state_d = S_FINISH;
        unique case (op_q)
          KIND_INSERT: begin
            if (found_q) begin
              val_we   = 1'b1;
              status_d = ST_UPDATED;
            end else if (count_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              wr_addr  = count_q[IW-1:0];
              key_we   = 1'b1;
              val_we   = 1'b1;
              count_d  = count_q + CW'(1);
              status_d = ST_APPENDED;
            end
          end
          KIND_REMOVE: begin
            if (found_q) begin
              status_d = ST_REMOVED;
              if (idx_ext + CW'(1) < count_q) begin
                state_d = S_SHIFT_RD;
              end else begin
                count_d = count_q - CW'(1);
              end
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          default: begin
            status_d = found_q ? ST_FOUND : ST_NOT_FOUND;
          end
        endcase
      end
      S_SHIFT_RD: begin
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        key_we = 1'b1;
        val_we = 1'b1;
        wr_key = rd_key_q;
        wr_val = rd_val_q;
        if (idx_ext + CW'(2) < count_q) begin
          idx_d   = idx_q + IW'(1);
          state_d = S_SHIFT_RD;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_d.status      = status_q;
          out_d.entry_count = cnt_ext[COUNT_W-1:0];
          out_d.table_empty = (count_q == '0);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // key and value memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (val_we) begin
      value_mem[wr_addr] <= wr_val;
    end
    rd_key_q <= key_mem[rd_addr];
    rd_val_q <= value_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working payload, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    found_q  <= found_d;
    op_q     <= op_d;
    key_q    <= key_d;
    val_q    <= val_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // a full report only comes from a table that really is full
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && status_q == ST_FULL) |-> (count_q == CW'(CAPACITY)))
    else $error("full status with room left");

  // an append always leaves the table non-empty
  a_append_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_APPENDED) |-> !out_q.table_empty)
    else $error("append reported an empty table");

  // the fill count only moves while an item is being resolved or shifted
  a_count_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_READ || state_q == S_CMP ||
     state_q == S_FINISH) |=> $stable(count_q))
    else $error("fill count changed outside an update");

endmodule
